// ===== hw/rtl/dtc_pkg.sv =====
// Shared types and constants of the decision tree classifier.
`default_nettype none
package dtc_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned TARGET_W   = 8;
  localparam int unsigned FEAT_IDX_W = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CLASS_W    = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned NCOUNT_W   = 9;
  localparam int unsigned FCOUNT_W   = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  // Node word bits that do not depend on the value width.
  localparam int unsigned NODE_FIXED_W = FEAT_IDX_W + KIND_W + 2 * (TARGET_W + 1);

  localparam logic [OPCODE_W-1:0] OP_WRITE_NODE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_FEAT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLASSIFY   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REAL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BINNOM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOMINAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_COUNT = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_FEAT   = 3'd1,
    ST_NOMINAL    = 3'd2,
    ST_NODE_RANGE = 3'd3,
    ST_BAD_KIND   = 3'd4,
    ST_STEP_LIMIT = 3'd5
  } dtc_status_e;

  typedef struct packed {
    logic                valid;
    logic [CLASS_W-1:0]  class_id;
    dtc_status_e         status;
  } dtc_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dtc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dtc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== hw/rtl/dtc_cmp.sv =====
// Shared compare unit: less-or-equal for real nodes, equality for binary nodes.
`default_nettype none
module dtc_cmp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic signed [VALUE_WIDTH-1:0] feature_i,
  input  wire logic signed [VALUE_WIDTH-1:0] threshold_i,
  input  wire logic                          is_equal_i,
  output logic                               take_le_o
);
  always_comb begin
    if (is_equal_i) begin
      take_le_o = (feature_i == threshold_i);
    end else begin
      take_le_o = (feature_i <= threshold_i);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dtc_seq.sv =====
// Tree walk sequencer: node fetch, feature fetch, compare and branch.
`default_nettype none
module dtc_seq #(
  parameter int unsigned MAX_NODES    = 256,
  parameter int unsigned MAX_FEATURES = 32,
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned STEP_LIMIT   = 256,
  localparam int unsigned NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int unsigned FEAT_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int unsigned NODE_W  = dtc_pkg::NODE_FIXED_W + VALUE_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              classify_i,
  input  wire logic [dtc_pkg::NCOUNT_W-1:0]      node_count_i,
  input  wire logic [dtc_pkg::FCOUNT_W-1:0]      feature_count_i,
  output logic                                   node_re_o,
  output logic      [NODE_AW-1:0]                node_raddr_o,
  input  wire logic [NODE_W-1:0]                 node_rdata_i,
  output logic                                   feat_re_o,
  output logic      [FEAT_AW-1:0]                feat_raddr_o,
  input  wire logic [VALUE_WIDTH-1:0]            feat_rdata_i,
  output logic                                   busy_o,
  output dtc_pkg::dtc_result_t                   result_o
);
  localparam int unsigned TW      = dtc_pkg::TARGET_W;
  localparam int unsigned GT_T    = 0;
  localparam int unsigned GT_C    = GT_T + TW;
  localparam int unsigned LE_T    = GT_C + 1;
  localparam int unsigned LE_C    = LE_T + TW;
  localparam int unsigned THR     = LE_C + 1;
  localparam int unsigned KIND    = THR + VALUE_WIDTH;
  localparam int unsigned FEAT    = KIND + dtc_pkg::KIND_W;
  localparam int unsigned STEP_W  = $clog2(STEP_LIMIT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_NODE,
    S_FEAT
  } state_e;

  state_e                            state_q;
  logic [TW-1:0]                     ptr_q;
  logic [STEP_W-1:0]                 steps_q;
  dtc_pkg::dtc_result_t              result_q;

  logic [dtc_pkg::FEAT_IDX_W-1:0]    nd_feat;
  logic [dtc_pkg::KIND_W-1:0]        nd_kind;
  logic signed [VALUE_WIDTH-1:0]     nd_thr;
  logic                              nd_le_c;
  logic [TW-1:0]                     nd_le_t;
  logic                              nd_gt_c;
  logic [TW-1:0]                     nd_gt_t;
  logic                              node_in_range;
  logic                              step_done;
  logic                              feat_bad;
  logic                              take_le;
  logic                              br_is_class;
  logic [TW-1:0]                     br_target;

  assign nd_gt_t = node_rdata_i[GT_T +: TW];
  assign nd_gt_c = node_rdata_i[GT_C];
  assign nd_le_t = node_rdata_i[LE_T +: TW];
  assign nd_le_c = node_rdata_i[LE_C];
  assign nd_thr  = node_rdata_i[THR +: VALUE_WIDTH];
  assign nd_kind = node_rdata_i[KIND +: dtc_pkg::KIND_W];
  assign nd_feat = node_rdata_i[FEAT +: dtc_pkg::FEAT_IDX_W];

  assign node_in_range = (dtc_pkg::NCOUNT_W'(ptr_q) < node_count_i) &&
                         (32'(ptr_q) < MAX_NODES);
  assign step_done     = (steps_q == STEP_W'(STEP_LIMIT));
  assign feat_bad      = (dtc_pkg::FEAT_IDX_W'(feature_count_i) <= nd_feat) ||
                         (32'(nd_feat) >= MAX_FEATURES);

  dtc_cmp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .feature_i   (feat_rdata_i),
    .threshold_i (nd_thr),
    .is_equal_i  (nd_kind == dtc_pkg::KIND_BINNOM),
    .take_le_o   (take_le)
  );

  assign br_is_class = take_le ? nd_le_c : nd_gt_c;
  assign br_target   = take_le ? nd_le_t : nd_gt_t;

  assign node_re_o    = (state_q == S_CHECK) && node_in_range && !step_done;
  assign node_raddr_o = NODE_AW'(ptr_q);
  assign feat_re_o    = (state_q == S_NODE) && !feat_bad &&
                        ((nd_kind == dtc_pkg::KIND_REAL) || (nd_kind == dtc_pkg::KIND_BINNOM));
  assign feat_raddr_o = FEAT_AW'(nd_feat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      ptr_q           <= '0;
      steps_q         <= '0;
      result_q.valid  <= 1'b0;
      result_q.class_id <= '0;
      result_q.status <= dtc_pkg::ST_OK;
    end else begin
      result_q.valid <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (classify_i) begin
            ptr_q   <= '0;
            steps_q <= '0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!node_in_range) begin
            result_q <= '{valid: 1'b1, class_id: '0, status: dtc_pkg::ST_NODE_RANGE};
            state_q  <= S_IDLE;
          end else if (step_done) begin
            result_q <= '{valid: 1'b1, class_id: '0, status: dtc_pkg::ST_STEP_LIMIT};
            state_q  <= S_IDLE;
          end else begin
            steps_q <= steps_q + 1'b1;
            state_q <= S_NODE;
          end
        end
        S_NODE: begin
          if (feat_bad) begin
            result_q <= '{valid: 1'b1, class_id: '0, status: dtc_pkg::ST_BAD_FEAT};
            state_q  <= S_IDLE;
          end else begin
            unique case (nd_kind)
              dtc_pkg::KIND_REAL, dtc_pkg::KIND_BINNOM: begin
                state_q <= S_FEAT;
              end
              dtc_pkg::KIND_NOMINAL: begin
                result_q <= '{valid: 1'b1, class_id: '0, status: dtc_pkg::ST_NOMINAL};
                state_q  <= S_IDLE;
              end
              default: begin
                result_q <= '{valid: 1'b1, class_id: '0, status: dtc_pkg::ST_BAD_KIND};
                state_q  <= S_IDLE;
              end
            endcase
          end
        end
        S_FEAT: begin
          if (br_is_class) begin
            result_q <= '{valid: 1'b1, class_id: br_target, status: dtc_pkg::ST_OK};
            state_q  <= S_IDLE;
          end else begin
            ptr_q   <= br_target;
            state_q <= S_CHECK;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign result_o = result_q;
endmodule
`default_nettype wire

// ===== hw/rtl/decision_tree_classifier_unit.sv =====
// Top level of the decision tree classifier: registers, stores and tree walk.
`default_nettype none
// The host loads tree nodes (opcode 0) and feature values (opcode 1) with one
// start pulse each; these give no result word and leave busy low. A classify
// command (opcode 2) walks the tree from node 0 and keeps busy high until it
// finishes. Each visited node passes through these steps of the walk: a
// range and step check that reads the node RAM, a node decode that reads the
// feature RAM, then one pass through the shared compare unit that picks the
// branch. A bad feature, nominal or unknown kind stops the walk in the node
// decode, and a node range or step limit stops it in the range and step
// check. The result word (class_id_o, status_o) is shown for exactly one
// cycle with done_o high in the cycle busy falls; the receiver cannot hold
// it, so it must be taken then. class_id_o is zero unless status_o is ok.
// Stores come up undefined and need no clearing; every node and feature
// reached by a walk must have been written first. node_count and
// feature_count are to be written through cfg_we_i only while the block is
// idle; the block itself does not enforce this. Values are signed fixed
// point of VALUE_WIDTH bits taken from the 32-bit input fields by sign
// extension or truncation.
module decision_tree_classifier_unit #(
  parameter int unsigned MAX_NODES    = 256,
  parameter int unsigned MAX_FEATURES = 32,
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned STEP_LIMIT   = 256
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [dtc_pkg::OPCODE_W-1:0]        opcode_i,
  input  wire logic [7:0]                          node_addr_i,
  input  wire logic [dtc_pkg::FEAT_IDX_W-1:0]      node_feature_i,
  input  wire logic [dtc_pkg::KIND_W-1:0]          node_kind_i,
  input  wire logic signed [31:0]                  node_threshold_i,
  input  wire logic                                le_is_class_i,
  input  wire logic [dtc_pkg::TARGET_W-1:0]        le_target_i,
  input  wire logic                                gt_is_class_i,
  input  wire logic [dtc_pkg::TARGET_W-1:0]        gt_target_i,
  input  wire logic [4:0]                          feature_addr_i,
  input  wire logic signed [31:0]                  feature_value_i,
  output logic                                     done_o,
  output logic      [dtc_pkg::CLASS_W-1:0]         class_id_o,
  output logic      [dtc_pkg::STATUS_W-1:0]        status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [dtc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  localparam int unsigned NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned FEAT_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned NODE_W  = dtc_pkg::NODE_FIXED_W + VALUE_WIDTH;

  logic [dtc_pkg::NCOUNT_W-1:0] node_count_q;
  logic [dtc_pkg::FCOUNT_W-1:0] feature_count_q;

  logic                         accept;
  logic                         node_we;
  logic                         feat_we;
  logic signed [63:0]           thr_ext;
  logic signed [63:0]           fval_ext;
  logic [NODE_W-1:0]            node_wdata;

  logic                         node_re;
  logic [NODE_AW-1:0]           node_raddr;
  logic [NODE_W-1:0]            node_rdata;
  logic                         feat_re;
  logic [FEAT_AW-1:0]           feat_raddr;
  logic [VALUE_WIDTH-1:0]       feat_rdata;
  dtc_pkg::dtc_result_t         result;

  // Configuration registers; the register index selects which one a write hits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q    <= '0;
      feature_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dtc_pkg::CFG_NODE_COUNT: node_count_q    <= cfg_wdata_i;
        dtc_pkg::CFG_FEAT_COUNT: feature_count_q <= cfg_wdata_i[dtc_pkg::FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A command word is taken whenever the walk is not running. Writes to slots
  // past the store depth are dropped.
  assign accept  = start && !busy;
  assign node_we = accept && (opcode_i == dtc_pkg::OP_WRITE_NODE) &&
                   (32'(node_addr_i) < MAX_NODES);
  assign feat_we = accept && (opcode_i == dtc_pkg::OP_WRITE_FEAT) &&
                   (32'(feature_addr_i) < MAX_FEATURES);

  // Sign-extend to the widest supported value width, then keep the low bits.
  assign thr_ext  = 64'(node_threshold_i);
  assign fval_ext = 64'(feature_value_i);

  // Node word layout, most significant first: feature index, kind, threshold,
  // true-branch flag and target, false-branch flag and target.
  assign node_wdata = {node_feature_i, node_kind_i, thr_ext[VALUE_WIDTH-1:0],
                       le_is_class_i, le_target_i, gt_is_class_i, gt_target_i};

  dtc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (NODE_AW'(node_addr_i)),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  dtc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_FEATURES)
  ) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (FEAT_AW'(feature_addr_i)),
    .wdata_i (fval_ext[VALUE_WIDTH-1:0]),
    .re_i    (feat_re),
    .raddr_i (feat_raddr),
    .rdata_o (feat_rdata)
  );

  dtc_seq #(
    .MAX_NODES    (MAX_NODES),
    .MAX_FEATURES (MAX_FEATURES),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .STEP_LIMIT   (STEP_LIMIT)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .classify_i      (accept && (opcode_i == dtc_pkg::OP_CLASSIFY)),
    .node_count_i    (node_count_q),
    .feature_count_i (feature_count_q),
    .node_re_o       (node_re),
    .node_raddr_o    (node_raddr),
    .node_rdata_i    (node_rdata),
    .feat_re_o       (feat_re),
    .feat_raddr_o    (feat_raddr),
    .feat_rdata_i    (feat_rdata),
    .busy_o          (busy),
    .result_o        (result)
  );

  assign done_o     = result.valid;
  assign class_id_o = result.class_id;
  assign status_o   = result.status;

  // A result word only appears as a walk ends.
  a_done_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result word without a running walk");

  // Errors never carry a class.
  a_error_no_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != dtc_pkg::ST_OK)) |-> (class_id_o == '0))
    else $error("class id set on an error result");

  // Only a classify command starts a walk.
  a_walk_from_classify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (opcode_i == dtc_pkg::OP_CLASSIFY)))
    else $error("walk started without a classify command");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the decision tree classifier unit.
module tb;

  // Codes the package does not name: the fourth opcode does nothing and the
  // fourth node kind is not a kind the walk knows.
  localparam logic [dtc_pkg::OPCODE_W-1:0] OP_NOP       = 2'd3;
  localparam logic [dtc_pkg::KIND_W-1:0]   KIND_UNKNOWN = 2'd3;

  // Sizes of the block as instantiated (its parameter defaults).
  localparam int unsigned NODE_SLOTS = 256;
  localparam int unsigned FEAT_SLOTS = 32;
  localparam int unsigned WALK_STEPS = 256;

  // The quiet limit is set above the longest classification plus the sender's
  // longest gap at heavy idling, so that only a hung block trips it.
  localparam int unsigned QUIET_LIMIT   = 8000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Register settings of the random phases, the extremes among them. Values
  // past the store sizes must act as the store sizes.
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_NC [PHASES] = '{16, 256, 1, 511, 8, 40, 0, 100};
  localparam int unsigned PHASE_FC [PHASES] = '{8, 32, 1, 63, 0, 20, 32, 5};
  localparam int unsigned PHASE_LEN[PHASES] = '{90, 330, 55, 95, 45, 95, 35, 90};

  // One command word as it is put on the input ports.
  typedef struct packed {
    logic [dtc_pkg::OPCODE_W-1:0]   opcode;
    logic [7:0]                     node_addr;
    logic [dtc_pkg::FEAT_IDX_W-1:0] node_feature;
    logic [dtc_pkg::KIND_W-1:0]     node_kind;
    logic [31:0]                    node_threshold;
    logic                           le_is_class;
    logic [dtc_pkg::TARGET_W-1:0]   le_target;
    logic                           gt_is_class;
    logic [dtc_pkg::TARGET_W-1:0]   gt_target;
    logic [4:0]                     feature_addr;
    logic [31:0]                    feature_value;
  } dtc_cmd_t;

  // One tree node as the walk sees it.
  typedef struct packed {
    logic [dtc_pkg::FEAT_IDX_W-1:0] feature;
    logic [dtc_pkg::KIND_W-1:0]     kind;
    logic [31:0]                    threshold;
    logic                           le_is_class;
    logic [dtc_pkg::TARGET_W-1:0]   le_target;
    logic                           gt_is_class;
    logic [dtc_pkg::TARGET_W-1:0]   gt_target;
  } tree_node_t;

  // One result word of a classification.
  typedef struct packed {
    logic [dtc_pkg::CLASS_W-1:0] class_id;
    dtc_pkg::dtc_status_e        status;
  } verdict_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           start       = 1'b0;
  logic                           busy;
  logic                           done_o;
  logic [dtc_pkg::CLASS_W-1:0]    class_id_o;
  logic [dtc_pkg::STATUS_W-1:0]   status_o;
  logic                           cfg_we_i    = 1'b0;
  logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [dtc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  dtc_cmd_t                       cur_cmd     = '0;

  // Set at each rising edge when the word on the ports was taken.
  logic word_taken = 1'b0;

  // Command words waiting to be sent, and results still owed by the block.
  dtc_cmd_t cmd_backlog[$];
  verdict_t verdicts_due[$];

  // Prediction state: the tree, the features and both count registers as
  // the block should hold them after every register write and accepted word.
  tree_node_t  tree_mem[NODE_SLOTS];
  logic [31:0] feat_mem[FEAT_SLOTS];
  int unsigned node_count_reg = 0;
  int unsigned feat_count_reg = 0;

  // Stimulus planning: which entries have been written, and the limits in
  // force for the phase being generated. A walk may only reach written
  // entries, so every phase first fills whatever is in range but unwritten.
  bit          node_written[NODE_SLOTS];
  bit          feat_written[FEAT_SLOTS];
  int unsigned plan_nc = 0;
  int unsigned plan_fc = 0;

  int unsigned sender_idle_pct = 0;
  int unsigned mismatches      = 0;
  int unsigned words_sent      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned status_hits[6];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  decision_tree_classifier_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (cur_cmd.opcode),
    .node_addr_i      (cur_cmd.node_addr),
    .node_feature_i   (cur_cmd.node_feature),
    .node_kind_i      (cur_cmd.node_kind),
    .node_threshold_i (cur_cmd.node_threshold),
    .le_is_class_i    (cur_cmd.le_is_class),
    .le_target_i      (cur_cmd.le_target),
    .gt_is_class_i    (cur_cmd.gt_is_class),
    .gt_target_i      (cur_cmd.gt_target),
    .feature_addr_i   (cur_cmd.feature_addr),
    .feature_value_i  (cur_cmd.feature_value),
    .done_o           (done_o),
    .class_id_o       (class_id_o),
    .status_o         (status_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // Walks the predicted tree from node 0. The range check comes before the
  // step limit, and the feature check before the node kind, as in the block.
  function automatic verdict_t walk_tree();
    int unsigned lim_n;
    int unsigned lim_f;
    int unsigned n;
    int unsigned steps;
    tree_node_t  nd;
    logic [31:0] fv;
    logic        take_le;
    logic        fin;
    verdict_t    v;
    lim_n = (node_count_reg > NODE_SLOTS) ? NODE_SLOTS : node_count_reg;
    lim_f = (feat_count_reg > FEAT_SLOTS) ? FEAT_SLOTS : feat_count_reg;
    n = 0;
    steps = 0;
    fin = 1'b0;
    v.class_id = '0;
    v.status = dtc_pkg::ST_OK;
    while (!fin) begin
      if (n >= lim_n) begin
        v.status = dtc_pkg::ST_NODE_RANGE;
        fin = 1'b1;
      end else if (steps >= WALK_STEPS) begin
        v.status = dtc_pkg::ST_STEP_LIMIT;
        fin = 1'b1;
      end else begin
        steps++;
        nd = tree_mem[n];
        if (32'(nd.feature) >= lim_f) begin
          v.status = dtc_pkg::ST_BAD_FEAT;
          fin = 1'b1;
        end else begin
          fv = feat_mem[nd.feature];
          take_le = 1'b0;
          case (nd.kind)
            dtc_pkg::KIND_REAL: begin
              take_le = $signed(fv) <= $signed(nd.threshold);
            end
            dtc_pkg::KIND_BINNOM: begin
              take_le = fv == nd.threshold;
            end
            dtc_pkg::KIND_NOMINAL: begin
              v.status = dtc_pkg::ST_NOMINAL;
              fin = 1'b1;
            end
            default: begin
              v.status = dtc_pkg::ST_BAD_KIND;
              fin = 1'b1;
            end
          endcase
          if (!fin) begin
            if (take_le && nd.le_is_class) begin
              v.class_id = nd.le_target;
              fin = 1'b1;
            end else if (take_le) begin
              n = 32'(nd.le_target);
            end else if (nd.gt_is_class) begin
              v.class_id = nd.gt_target;
              fin = 1'b1;
            end else begin
              n = 32'(nd.gt_target);
            end
          end
        end
      end
    end
    return v;
  endfunction

  // Values near the extremes and a few round Q16.16 numbers come up often so
  // that equality splits and boundary compares actually happen.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A word with every field random except the opcode; fields an opcode does
  // not use are therefore noise as well.
  function automatic dtc_cmd_t junk_cmd(input logic [dtc_pkg::OPCODE_W-1:0] op);
    dtc_cmd_t c;
    c.opcode         = op;
    c.node_addr      = 8'($urandom_range(255));
    c.node_feature   = 8'($urandom_range(255));
    c.node_kind      = 2'($urandom_range(3));
    c.node_threshold = $urandom();
    c.le_is_class    = 1'($urandom_range(1));
    c.le_target      = 8'($urandom_range(255));
    c.gt_is_class    = 1'($urandom_range(1));
    c.gt_target      = 8'($urandom_range(255));
    c.feature_addr   = 5'($urandom_range(31));
    c.feature_value  = $urandom();
    return c;
  endfunction

  function automatic dtc_cmd_t node_cmd(input logic [7:0] addr, input logic [7:0] feat,
                                        input logic [dtc_pkg::KIND_W-1:0] kind,
                                        input logic [31:0] thr,
                                        input logic le_cls, input logic [7:0] le_tgt,
                                        input logic gt_cls, input logic [7:0] gt_tgt);
    dtc_cmd_t c;
    c = junk_cmd(dtc_pkg::OP_WRITE_NODE);
    c.node_addr      = addr;
    c.node_feature   = feat;
    c.node_kind      = kind;
    c.node_threshold = thr;
    c.le_is_class    = le_cls;
    c.le_target      = le_tgt;
    c.gt_is_class    = gt_cls;
    c.gt_target      = gt_tgt;
    return c;
  endfunction

  function automatic dtc_cmd_t feat_cmd(input logic [4:0] addr, input logic [31:0] val);
    dtc_cmd_t c;
    c = junk_cmd(dtc_pkg::OP_WRITE_FEAT);
    c.feature_addr  = addr;
    c.feature_value = val;
    return c;
  endfunction

  // Children mostly point further down an in-range tree, which keeps walks
  // long and acyclic; the rest point anywhere, giving loops and range errors.
  function automatic logic [dtc_pkg::TARGET_W-1:0] child_target(input int unsigned addr);
    if (addr + 1 < plan_nc && $urandom_range(9) != 0) begin
      return 8'($urandom_range(plan_nc - 1, addr + 1));
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed nodes for the current limits, the rest pure noise.
  function automatic dtc_cmd_t tree_node_cmd(input int unsigned addr);
    dtc_cmd_t    c;
    int unsigned r;
    c = junk_cmd(dtc_pkg::OP_WRITE_NODE);
    c.node_addr = 8'(addr);
    if ($urandom_range(99) < 85) begin
      if (plan_fc != 0 && $urandom_range(9) != 0) begin
        c.node_feature = 8'($urandom_range(plan_fc - 1));
      end
      r = $urandom_range(19);
      c.node_kind = (r < 10) ? dtc_pkg::KIND_REAL : (r < 17) ? dtc_pkg::KIND_BINNOM :
                    (r < 18) ? dtc_pkg::KIND_NOMINAL : KIND_UNKNOWN;
      c.node_threshold = pick_value();
      c.le_is_class = $urandom_range(9) < 4;
      c.gt_is_class = $urandom_range(9) < 4;
      if (!c.le_is_class) begin
        c.le_target = child_target(addr);
      end
      if (!c.gt_is_class) begin
        c.gt_target = child_target(addr);
      end
    end
    return c;
  endfunction

  function automatic void enqueue(input dtc_cmd_t c);
    if (c.opcode == dtc_pkg::OP_WRITE_NODE) begin
      node_written[c.node_addr] = 1'b1;
    end
    if (c.opcode == dtc_pkg::OP_WRITE_FEAT) begin
      feat_written[c.feature_addr] = 1'b1;
    end
    cmd_backlog.push_back(c);
  endfunction

  // Waits until every word has gone out and every result has come back,
  // then waits out the settle cycles so that a last write has surely landed.
  task automatic settle();
    do begin
      @(posedge clk_i);
    end while (cmd_backlog.size() != 0 || start || verdicts_due.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both count registers in back-to-back cycles while idle.
  task automatic write_counts(input int unsigned nc, input int unsigned fc);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dtc_pkg::CFG_NODE_COUNT;
    cfg_wdata_i <= nc[dtc_pkg::CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_index_i <= dtc_pkg::CFG_FEAT_COUNT;
    cfg_wdata_i <= fc[dtc_pkg::CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    plan_nc = (nc > NODE_SLOTS) ? NODE_SLOTS : nc;
    plan_fc = (fc > FEAT_SLOTS) ? FEAT_SLOTS : fc;
  endtask

  // One random phase: new counts, fill of the unwritten entries in range,
  // then a mix of node writes, feature writes, classifications and no-ops.
  task automatic run_phase(input int unsigned nc, input int unsigned fc, input int len);
    int          left;
    int unsigned r;
    int unsigned addr;
    dtc_cmd_t    c;
    settle();
    write_counts(nc, fc);
    left = len;
    for (int i = 0; i < int'(plan_fc); i++) begin
      if (!feat_written[i]) begin
        enqueue(feat_cmd(5'(i), pick_value()));
        left--;
      end
    end
    for (int i = 0; i < int'(plan_nc); i++) begin
      if (!node_written[i]) begin
        enqueue(tree_node_cmd(32'(i)));
        left--;
      end
    end
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 33) begin
        addr = (plan_nc != 0 && $urandom_range(9) != 0) ? $urandom_range(plan_nc - 1) :
               $urandom_range(255);
        c = tree_node_cmd(addr);
      end else if (r < 58) begin
        c = feat_cmd(5'($urandom_range(31)), pick_value());
      end else if (r < 95) begin
        c = junk_cmd(dtc_pkg::OP_CLASSIFY);
      end else begin
        c = junk_cmd(OP_NOP);
      end
      enqueue(c);
      left--;
    end
  endtask

  // Driver: at each falling edge a taken word is replaced by the next one,
  // or start drops and the sender idles. A word not yet taken is held as it is.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || word_taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        cur_cmd <= cmd_backlog.pop_front();
        start   <= 1'b1;
      end else begin
        start   <= 1'b0;
      end
    end
  end

  // Monitor and predictor: at each rising edge the result word is checked
  // against the oldest prediction first, then register writes and the taken
  // command word update the prediction state. A classify that is taken on the
  // edge where the previous result is shown thus queues behind it.
  always @(posedge clk_i) begin
    verdict_t want;
    word_taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (done_o) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: class_id %0d status %0d",
                   $time, class_id_o, status_o);
        end else begin
          want = verdicts_due.pop_front();
          status_hits[want.status]++;
          if (class_id_o !== want.class_id) begin
            mismatches++;
            $display("%0t: class_id expected %0d actual %0d", $time, want.class_id,
                     class_id_o);
          end
          if (status_o !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          end
        end
      end

      if (cfg_we_i) begin
        if (cfg_index_i == dtc_pkg::CFG_NODE_COUNT) begin
          node_count_reg = 32'(cfg_wdata_i[dtc_pkg::NCOUNT_W-1:0]);
        end else begin
          feat_count_reg = 32'(cfg_wdata_i[dtc_pkg::FCOUNT_W-1:0]);
        end
      end

      if (start && !busy) begin
        words_sent++;
        case (cur_cmd.opcode)
          dtc_pkg::OP_WRITE_NODE: begin
            tree_mem[cur_cmd.node_addr] = {cur_cmd.node_feature, cur_cmd.node_kind,
                                           cur_cmd.node_threshold, cur_cmd.le_is_class,
                                           cur_cmd.le_target, cur_cmd.gt_is_class,
                                           cur_cmd.gt_target};
          end
          dtc_pkg::OP_WRITE_FEAT: begin
            feat_mem[cur_cmd.feature_addr] = cur_cmd.feature_value;
          end
          dtc_pkg::OP_CLASSIFY: begin
            verdicts_due.push_back(walk_tree());
          end
          default: begin
          end
        endcase
      end

      // Watchdog: a long stretch with neither a taken word nor a result
      // means the block has hung.
      if ((start && !busy) || done_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. With no nodes in use even node 0 is out of range; the
    // no-op must give nothing.
    sender_idle_pct = 38;
    write_counts(0, 0);
    enqueue(junk_cmd(OP_NOP));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    settle();

    // Four nodes, two features; the features hold the two value extremes.
    write_counts(4, 2);
    enqueue(feat_cmd(5'd0, 32'h7FFF_FFFF));
    enqueue(feat_cmd(5'd1, 32'h8000_0000));
    // Largest value against the largest threshold: the true branch is taken.
    enqueue(node_cmd(8'd0, 8'd0, dtc_pkg::KIND_REAL, 32'h7FFF_FFFF, 1'b1, 8'd255, 1'b1,
                     8'd1));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    // Smallest value against the smallest threshold.
    enqueue(node_cmd(8'd0, 8'd1, dtc_pkg::KIND_REAL, 32'h8000_0000, 1'b1, 8'd7, 1'b1,
                     8'd9));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    // Equality miss at node 0 leads to node 1, whose equality hit gives class 0.
    enqueue(node_cmd(8'd1, 8'd1, dtc_pkg::KIND_BINNOM, 32'h8000_0000, 1'b1, 8'd0, 1'b1,
                     8'd3));
    enqueue(node_cmd(8'd0, 8'd0, dtc_pkg::KIND_BINNOM, 32'h7FFF_FFFE, 1'b1, 8'd5, 1'b0,
                     8'd1));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    // Feature index just past the count.
    enqueue(node_cmd(8'd0, 8'd2, dtc_pkg::KIND_REAL, 32'h0, 1'b1, 8'd1, 1'b1, 8'd2));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    // A bad feature is reported even when the kind is unknown too.
    enqueue(node_cmd(8'd0, 8'd255, KIND_UNKNOWN, 32'h0, 1'b1, 8'd1, 1'b1, 8'd2));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    enqueue(node_cmd(8'd0, 8'd0, KIND_UNKNOWN, 32'h0, 1'b1, 8'd1, 1'b1, 8'd2));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    enqueue(node_cmd(8'd0, 8'd0, dtc_pkg::KIND_NOMINAL, 32'h0, 1'b1, 8'd1, 1'b1, 8'd2));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    // False branch to a child past the node count.
    enqueue(node_cmd(8'd0, 8'd0, dtc_pkg::KIND_REAL, 32'h0, 1'b1, 8'd1, 1'b0, 8'd200));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    // Node 0 points at itself on both branches, so the walk runs into the
    // step limit.
    enqueue(node_cmd(8'd0, 8'd0, dtc_pkg::KIND_REAL, 32'h0, 1'b0, 8'd0, 1'b0, 8'd0));
    enqueue(junk_cmd(dtc_pkg::OP_CLASSIFY));
    // Highest slots of both stores.
    enqueue(node_cmd(8'd255, 8'd255, KIND_UNKNOWN, 32'h8000_0000, 1'b1, 8'd255, 1'b1,
                     8'd255));
    enqueue(feat_cmd(5'd31, 32'hFFFF_FFFF));

    // Random part: the sender idles with a chance of 38 percent, then 76, then never.
    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = (p < 3) ? 38 : (p < 6) ? 76 : 0;
      run_phase(PHASE_NC[p], PHASE_FC[p], PHASE_LEN[p]);
    end
    settle();

    $display("Sent %0d command words over %0d register settings.", words_sent, PHASES + 2);
    $display("Classifications by status: ok %0d, bad feature %0d, nominal %0d,",
             status_hits[dtc_pkg::ST_OK], status_hits[dtc_pkg::ST_BAD_FEAT],
             status_hits[dtc_pkg::ST_NOMINAL]);
    $display("  node range %0d, bad kind %0d, step limit %0d.",
             status_hits[dtc_pkg::ST_NODE_RANGE], status_hits[dtc_pkg::ST_BAD_KIND],
             status_hits[dtc_pkg::ST_STEP_LIMIT]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dtc_pkg.sv
hw/rtl/dtc_ram.sv
hw/rtl/dtc_cmp.sv
hw/rtl/dtc_seq.sv
hw/rtl/decision_tree_classifier_unit.sv
tb/sv/tb.sv
